[sv/mdpa_pkg.sv]
// Shared constants for the modular dot product accumulator.
`timescale 1ns / 1ps

package mdpa_pkg;

  // Default residue width.
  localparam int WORD_BITS_DEF = 31;

  // Operand selector codes used while reducing the latched operands.
  localparam logic [1:0] OPND_A    = 2'd0;
  localparam logic [1:0] OPND_B    = 2'd1;
  localparam logic [1:0] OPND_SUM  = 2'd2;
  localparam logic [1:0] OPND_PREV = 2'd3;

endpackage

[sv/modular_dot_product_accumulate_top.sv]
// Modular dot product accumulator: one term per transaction, one result per run.
// Each input transaction carries a term of a dot product over one limb:
// two residues a_val and b_val, the limb modulus, an earlier result prev_val
// and a last flag. The block folds a_val*b_val mod modulus into a running sum.
// On a term with last set it emits (prev_val + sum) mod modulus and then clears
// the sum. A zero modulus clears the sum and, with last set, gives a zero
// result. Every addition runs through a single add-and-reduce unit:
// t = u + v, then t, t - m or t - 2m is kept. A small sequencer steps this unit
// one bit per cycle. With in-range operands a term is accepted and then passes
// four operand range checks, WORD_BITS shift-and-add multiply steps and one
// accumulate step before the next term can be accepted. A term with last set
// then also combines with prev_val and hands off the result. Each operand, or
// a stored sum, that is not below the modulus first goes through WORD_BITS
// steps of bit-serial reduction and one more range check. A term with a zero
// modulus skips the range checks and the arithmetic; with last set it goes
// straight to the hand-off. The input is ready only while the sequencer is
// idle. A finished result waits in the output register and does not block
// the next term until the next result is due.
`timescale 1ns / 1ps

module modular_dot_product_accumulate_top #(
  parameter int WORD_BITS = mdpa_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_BITS-1:0] in_a_val,
  input  logic [WORD_BITS-1:0] in_b_val,
  input  logic [WORD_BITS-1:0] in_modulus,
  input  logic [WORD_BITS-1:0] in_prev_val,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_BITS-1:0] out_sum_out
);

  import mdpa_pkg::*;

  localparam int CNT_BITS = $clog2(WORD_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_RED  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_PRV  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [1:0]           sel_r, sel_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] a_r, a_nxt;
  logic [WORD_BITS-1:0] b_r, b_nxt;
  logic [WORD_BITS-1:0] m_r, m_nxt;
  logic [WORD_BITS-1:0] p_r, p_nxt;
  logic                 last_r, last_nxt;
  logic [WORD_BITS-1:0] sum_r, sum_nxt;
  logic [WORD_BITS-1:0] x_r, x_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [WORD_BITS-1:0] res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_r, out_nxt;

  // Shared add-and-reduce unit. Inputs satisfy u + v < 3m.
  logic [WORD_BITS:0]   unit_u, unit_v;
  logic [WORD_BITS+1:0] unit_t, unit_m1, unit_m2;
  logic [WORD_BITS-1:0] unit_res;

  logic [WORD_BITS-1:0] opnd;
  logic                 in_fire;

  assign unit_t  = {1'b0, unit_u} + {1'b0, unit_v};
  assign unit_m1 = {2'b00, m_r};
  assign unit_m2 = {1'b0, m_r, 1'b0};

  always_comb begin
    if (unit_t >= unit_m2) begin
      unit_res = WORD_BITS'(unit_t - unit_m2);
    end else if (unit_t >= unit_m1) begin
      unit_res = WORD_BITS'(unit_t - unit_m1);
    end else begin
      unit_res = WORD_BITS'(unit_t);
    end
  end

  always_comb begin
    case (sel_r)
      OPND_A:    opnd = a_r;
      OPND_B:    opnd = b_r;
      OPND_SUM:  opnd = sum_r;
      OPND_PREV: opnd = p_r;
      default:   opnd = a_r;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_sum_out = out_r;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    cnt_nxt       = cnt_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    m_nxt         = m_r;
    p_nxt         = p_r;
    last_nxt      = last_r;
    sum_nxt       = sum_r;
    x_nxt         = x_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unit_u        = {acc_r, 1'b0};
    unit_v        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          a_nxt    = in_a_val;
          b_nxt    = in_b_val;
          m_nxt    = in_modulus;
          p_nxt    = in_prev_val;
          last_nxt = in_last;
          sel_nxt  = OPND_A;
          if (in_modulus == '0) begin
            // A zero modulus contributes nothing and yields a zero result.
            sum_nxt = '0;
            res_nxt = '0;
            if (in_last) begin
              state_nxt = ST_FIN;
            end
          end else begin
            state_nxt = ST_CHK;
          end
        end
      end

      ST_CHK: begin
        if (opnd < m_r) begin
          sel_nxt = sel_r + 2'd1;
          if (sel_r == OPND_PREV) begin
            state_nxt = ST_MUL;
            x_nxt     = b_r;
            acc_nxt   = '0;
            cnt_nxt   = CNT_LAST;
          end
        end else begin
          state_nxt = ST_RED;
          x_nxt     = opnd;
          acc_nxt   = '0;
          cnt_nxt   = CNT_LAST;
        end
      end

      ST_RED: begin
        // Restoring reduction: acc = (2*acc + next bit) mod m.
        unit_u  = {acc_r, 1'b0};
        unit_v  = {{WORD_BITS{1'b0}}, x_r[WORD_BITS-1]};
        acc_nxt = unit_res;
        x_nxt   = {x_r[WORD_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_BITS'(1);
        if (cnt_r == '0) begin
          case (sel_r)
            OPND_A:    a_nxt   = unit_res;
            OPND_B:    b_nxt   = unit_res;
            OPND_SUM:  sum_nxt = unit_res;
            OPND_PREV: p_nxt   = unit_res;
            default:   a_nxt   = unit_res;
          endcase
          state_nxt = ST_CHK;
        end
      end

      ST_MUL: begin
        // Shift-and-add multiply, one bit of b per cycle from the top.
        unit_u  = {acc_r, 1'b0};
        unit_v  = x_r[WORD_BITS-1] ? {1'b0, a_r} : '0;
        acc_nxt = unit_res;
        x_nxt   = {x_r[WORD_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_BITS'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_ADD;
        end
      end

      ST_ADD: begin
        unit_u    = {1'b0, sum_r};
        unit_v    = {1'b0, acc_r};
        sum_nxt   = unit_res;
        state_nxt = last_r ? ST_PRV : ST_IDLE;
      end

      ST_PRV: begin
        unit_u    = {1'b0, p_r};
        unit_v    = {1'b0, sum_r};
        res_nxt   = unit_res;
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        // Wait here only while an earlier result is still unclaimed.
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          sum_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= OPND_A;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
    p_r   <= p_nxt;
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

endmodule
